@@ rtl/core/pidc_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes and stage payload types for the PID step.
// -----------------------------------------------------------------------------
package pidc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 8;
	localparam int REG_W     = 16;
	localparam int IDX_W     = 3;
	localparam int DRIVE_W   = 24;

	// Limits scaled to the sample's fixed-point format.
	localparam int LIM_W   = REG_W + FRAC_BITS;
	localparam int ERR_W   = ((SAMPLE_W > REG_W) ? SAMPLE_W : REG_W) + 1;
	localparam int DER_W   = SAMPLE_W + 1;
	localparam int INTEG_W = 25;
	localparam int ISUM_W  = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
	localparam int PROD_P_W = REG_W + ERR_W;
	localparam int PROD_I_W = REG_W + INTEG_W;
	localparam int PROD_D_W = REG_W + DER_W;
	localparam int PROD_MAX_W = (PROD_P_W > PROD_I_W) ?
		((PROD_P_W > PROD_D_W) ? PROD_P_W : PROD_D_W) :
		((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W);
	localparam int ACC_W   = PROD_MAX_W + 2;
	localparam int SHIFT_W = ACC_W - FRAC_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_SETPOINT = 3'd1,
		REG_GAIN_P   = 3'd2,
		REG_GAIN_I   = 3'd3,
		REG_GAIN_D   = 3'd4,
		REG_OUT_MIN  = 3'd5,
		REG_OUT_MAX  = 3'd6
	} reg_idx_t;

	localparam logic signed [REG_W-1:0] OUT_MAX_RESET = 16'sd255;

	// Error, clamped integral and derivative for one transaction.
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DER_W-1:0]   der;
		logic                      upd;
	} terms_t;

	// The three gain products for one transaction.
	typedef struct packed {
		logic signed [PROD_P_W-1:0] prod_p;
		logic signed [PROD_I_W-1:0] prod_i;
		logic signed [PROD_D_W-1:0] prod_d;
		logic                       upd;
	} prods_t;

endpackage
`default_nettype wire

@@ rtl/core/pid_step_with_clamped_integral_top.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// pid_step_with_clamped_integral_top
// Fixed-point PID step with clamped integral, four register stages.
// -----------------------------------------------------------------------------
// A sample moves through the s1, s2 and s3 registers to the output register.
// Throughput: one sample per cycle; the whole pipeline advances together and
// stalls only while a finished result waits at the output register.
// Reset: asynchronous, active low; clears integral, last sample, held drive and
// registers, except out_max which comes up at 255.
module pid_step_with_clamped_integral_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  write_enable,
	input  wire logic [pidc_pkg::IDX_W-1:0]            reg_index,
	input  wire logic [pidc_pkg::REG_W-1:0]            write_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  clear,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [pidc_pkg::DRIVE_W-1:0]        drive,
	output logic                                       updated
);

	localparam int RW = pidc_pkg::REG_W;

	logic                                 enable_q;
	logic signed [RW-1:0]                 setpoint_q;
	logic signed [RW-1:0]                 gain_p_q;
	logic signed [RW-1:0]                 gain_i_q;
	logic signed [RW-1:0]                 gain_d_q;
	logic signed [RW-1:0]                 out_min_q;
	logic signed [RW-1:0]                 out_max_q;
	logic signed [pidc_pkg::LIM_W-1:0]    lim_lo;
	logic signed [pidc_pkg::LIM_W-1:0]    lim_hi;
	logic                                 adv;
	logic                                 valid_s1;
	logic signed [pidc_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 clear_s1;
	pidc_pkg::terms_t                     terms_s2;
	logic                                 valid_s2;
	pidc_pkg::prods_t                     prods_s3;
	logic                                 valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			setpoint_q <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			out_min_q <= '0;
			out_max_q <= pidc_pkg::OUT_MAX_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				pidc_pkg::REG_ENABLE:   enable_q <= write_data[0];
				pidc_pkg::REG_SETPOINT: setpoint_q <= write_data;
				pidc_pkg::REG_GAIN_P:   gain_p_q <= write_data;
				pidc_pkg::REG_GAIN_I:   gain_i_q <= write_data;
				pidc_pkg::REG_GAIN_D:   gain_d_q <= write_data;
				pidc_pkg::REG_OUT_MIN:  out_min_q <= write_data;
				pidc_pkg::REG_OUT_MAX:  out_max_q <= write_data;
				default: ;
			endcase
		end
	end

	// Limits are given in whole units and compared in the sample's format.
	assign lim_lo = {out_min_q, {pidc_pkg::FRAC_BITS{1'b0}}};
	assign lim_hi = {out_max_q, {pidc_pkg::FRAC_BITS{1'b0}}};

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
			clear_s1 <= clear;
		end
	end

	pidc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1),
		.clear_s1  (clear_s1),
		.enable    (enable_q),
		.setpoint  (setpoint_q),
		.lim_lo    (lim_lo),
		.lim_hi    (lim_hi),
		.terms_s2  (terms_s2),
		.valid_s2  (valid_s2)
	);

	pidc_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.terms_s2 (terms_s2),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.prods_s3 (prods_s3),
		.valid_s3 (valid_s3)
	);

	pidc_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_s3    (valid_s3),
		.prods_s3    (prods_s3),
		.lim_lo      (lim_lo),
		.lim_hi      (lim_hi),
		.drive_q     (drive),
		.updated_q   (updated),
		.out_valid_q (out_valid)
	);

endmodule
`default_nettype wire

@@ rtl/core/pidc_state.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// pidc_state
// Error, integral update with clamp and derivative; holds integral and last sample.
// -----------------------------------------------------------------------------
module pidc_state (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  adv,
	input  wire logic                                  valid_s1,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0]  sample_s1,
	input  wire logic                                  clear_s1,
	input  wire logic                                  enable,
	input  wire logic signed [pidc_pkg::REG_W-1:0]     setpoint,
	input  wire logic signed [pidc_pkg::LIM_W-1:0]     lim_lo,
	input  wire logic signed [pidc_pkg::LIM_W-1:0]     lim_hi,
	output pidc_pkg::terms_t                           terms_s2,
	output logic                                       valid_s2
);

	localparam int EW = pidc_pkg::ERR_W;
	localparam int SW = pidc_pkg::SAMPLE_W;
	localparam int RW = pidc_pkg::REG_W;
	localparam int IW = pidc_pkg::INTEG_W;
	localparam int UW = pidc_pkg::ISUM_W;
	localparam int LW = pidc_pkg::LIM_W;
	localparam int DW = pidc_pkg::DER_W;

	logic signed [IW-1:0] integ_q;
	logic signed [SW-1:0] prev_q;
	logic signed [EW-1:0] err;
	logic signed [UW-1:0] isum;
	logic signed [UW-1:0] hi_ext;
	logic signed [UW-1:0] lo_ext;
	logic signed [IW-1:0] integ_new;
	logic signed [DW-1:0] der;

	always_comb begin
		err = {{(EW-RW){setpoint[RW-1]}}, setpoint} - {{(EW-SW){sample_s1[SW-1]}}, sample_s1};
		isum = {{(UW-IW){integ_q[IW-1]}}, integ_q} + {{(UW-EW){err[EW-1]}}, err};
		hi_ext = {{(UW-LW){lim_hi[LW-1]}}, lim_hi};
		lo_ext = {{(UW-LW){lim_lo[LW-1]}}, lim_lo};
		// The upper limit is checked first; with crossed limits a sum above it settles on it, any other on the lower.
		if (isum > hi_ext) begin
			integ_new = hi_ext[IW-1:0];
		end else if (isum < lo_ext) begin
			integ_new = lo_ext[IW-1:0];
		end else begin
			integ_new = isum[IW-1:0];
		end
		der = {sample_s1[SW-1], sample_s1} - {prev_q[SW-1], prev_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (clear_s1) begin
					integ_q <= '0;
					prev_q <= '0;
				end else if (enable) begin
					integ_q <= integ_new;
					prev_q <= sample_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			terms_s2.err <= err;
			terms_s2.integ <= integ_new;
			terms_s2.der <= der;
			terms_s2.upd <= !clear_s1 && enable;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pidc_mult.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// pidc_mult
// The three gain multiplications, registered.
// -----------------------------------------------------------------------------
module pidc_mult (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic                              valid_s2,
	input  wire pidc_pkg::terms_t                  terms_s2,
	input  wire logic signed [pidc_pkg::REG_W-1:0] gain_p,
	input  wire logic signed [pidc_pkg::REG_W-1:0] gain_i,
	input  wire logic signed [pidc_pkg::REG_W-1:0] gain_d,
	output pidc_pkg::prods_t                       prods_s3,
	output logic                                   valid_s3
);

	logic signed [pidc_pkg::PROD_P_W-1:0] prod_p;
	logic signed [pidc_pkg::PROD_I_W-1:0] prod_i;
	logic signed [pidc_pkg::PROD_D_W-1:0] prod_d;

	always_comb begin
		prod_p = gain_p * $signed(terms_s2.err);
		prod_i = gain_i * $signed(terms_s2.integ);
		prod_d = gain_d * $signed(terms_s2.der);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prods_s3.prod_p <= prod_p;
			prods_s3.prod_i <= prod_i;
			prods_s3.prod_d <= prod_d;
			prods_s3.upd <= terms_s2.upd;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pidc_out.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// pidc_out
// Sums the products, drops the fraction, clamps and holds the drive.
// -----------------------------------------------------------------------------
module pidc_out (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic                                 valid_s3,
	input  wire pidc_pkg::prods_t                     prods_s3,
	input  wire logic signed [pidc_pkg::LIM_W-1:0]    lim_lo,
	input  wire logic signed [pidc_pkg::LIM_W-1:0]    lim_hi,
	output logic signed [pidc_pkg::DRIVE_W-1:0]       drive_q,
	output logic                                      updated_q,
	output logic                                      out_valid_q
);

	localparam int AW  = pidc_pkg::ACC_W;
	localparam int PW  = pidc_pkg::PROD_P_W;
	localparam int IW  = pidc_pkg::PROD_I_W;
	localparam int DW  = pidc_pkg::PROD_D_W;
	localparam int SHW = pidc_pkg::SHIFT_W;
	localparam int LW  = pidc_pkg::LIM_W;
	localparam int OW  = pidc_pkg::DRIVE_W;

	logic signed [OW-1:0]  held_q;
	logic signed [AW-1:0]  acc;
	logic signed [SHW-1:0] shifted;
	logic signed [SHW-1:0] hi_ext;
	logic signed [SHW-1:0] lo_ext;
	logic signed [SHW-1:0] clamped;
	logic signed [OW-1:0]  drive_new;

	always_comb begin
		acc = {{(AW-PW){prods_s3.prod_p[PW-1]}}, prods_s3.prod_p}
			+ {{(AW-IW){prods_s3.prod_i[IW-1]}}, prods_s3.prod_i}
			+ {{(AW-DW){prods_s3.prod_d[DW-1]}}, prods_s3.prod_d};
		// Dropping the low bits of a two's complement value rounds towards minus infinity.
		shifted = acc[AW-1:pidc_pkg::FRAC_BITS];
		hi_ext = {{(SHW-LW){lim_hi[LW-1]}}, lim_hi};
		lo_ext = {{(SHW-LW){lim_lo[LW-1]}}, lim_lo};
		if (shifted > hi_ext) begin
			clamped = hi_ext;
		end else if (shifted < lo_ext) begin
			clamped = lo_ext;
		end else begin
			clamped = shifted;
		end
		drive_new = clamped[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
			if (valid_s3 && prods_s3.upd) begin
				held_q <= drive_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= prods_s3.upd ? drive_new : held_q;
			updated_q <= prods_s3.upd;
		end
	end

endmodule
`default_nettype wire
